// ----- hdl/sha256h_pkg.sv -----
// shared types and constants for the sha-256 message hasher
// used by every module under hdl; no dependencies
package sha256h_pkg;

    localparam int WORD_W = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_item;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word_0;
        logic [31:0] digest_word_1;
        logic [31:0] digest_word_2;
        logic [31:0] digest_word_3;
        logic [31:0] digest_word_4;
        logic [31:0] digest_word_5;
        logic [31:0] digest_word_6;
        logic [31:0] digest_word_7;
    } digest_t;

    // one big-endian message word on its way to the compression core
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              end_block;
        logic              final_block;
    } word_item_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- hdl/sha256_message_hasher.sv -----
// top level of the sha-256 message hasher
// depends on sha256h_pkg, sha256h_front, sha256h_queue, sha256h_core
//
// Streams a message in one byte per item; the item with last_item set ends
// the message, with or without a byte, and one digest item follows. Bytes
// are packed into words that wait in a short queue for the compression core.
// The core pops one word per cycle into its schedule window while it loads
// and the queue holds a word, then runs one round per cycle and a chaining
// step per block. While the rounds run, the queue fills and the input stalls,
// because in_ready falls whenever the queue is full. On long messages only
// 16 bytes enter during the rounds. The other 48 arrive one per cycle while
// the core loads. The cost of a block is therefore its load, its rounds and
// its chaining step, and it is set by the single round unit together with
// the queue depth. After the end mark the front end produces one padding
// word per cycle while the queue has room, so the closing block loads
// without further input. The padding may spill into a block of its own. The
// digest is held in an output register, so the next message may already be
// entering while it waits to be taken.
module sha256_message_hasher
    import sha256h_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output digest_t  out_data
);

    logic       push, push_ready, pop, pop_valid;
    word_item_t push_item, pop_item;

    // byte packing and padding
    sha256h_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_item (push_item),
        .push_ready(push_ready)
    );

    // word queue
    sha256h_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .push_ready(push_ready),
        .pop       (pop),
        .pop_item  (pop_item),
        .pop_valid (pop_valid)
    );

    // compression and digest
    sha256h_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_valid(pop_valid),
        .pop_item (pop_item),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

endmodule

// ----- hdl/sha256h_front.sv -----
// front end: packs bytes into words, counts length, generates padding
// depends on sha256h_pkg
module sha256h_front
    import sha256h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       push,
    output word_item_t push_item,
    input  logic       push_ready
);

    localparam logic [2:0] PS_IDLE  = 3'd0;
    localparam logic [2:0] PS_FIRST = 3'd1;
    localparam logic [2:0] PS_ZERO  = 3'd2;
    localparam logic [2:0] PS_LENHI = 3'd3;
    localparam logic [2:0] PS_LENLO = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [3:0]  idx_reg, idx_next;
    logic [63:0] bits_reg, bits_next;

    logic        accept;
    logic [31:0] acc_byte;
    logic [3:0]  idx_inc;

    assign in_ready = (state_reg == PS_IDLE) && push_ready;
    assign accept   = in_valid && in_ready;
    assign acc_byte = acc_reg | ({in_data.data_byte, 24'b0} >> {cnt_reg, 3'b000});
    assign idx_inc  = idx_reg + 4'd1;

    // byte packing and padding sequence
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        bits_next  = bits_reg;
        push       = 1'b0;
        push_item  = '{word: acc_byte, end_block: (idx_reg == 4'd15), final_block: 1'b0};
        case (state_reg)
            PS_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.byte_present)
                    begin
                        bits_next = bits_reg + 64'd8;
                        cnt_next  = cnt_reg + 2'd1;
                        if (cnt_reg == 2'd3)
                        begin
                            push     = 1'b1;
                            acc_next = '0;
                            idx_next = idx_inc;
                        end
                        else
                        begin
                            acc_next = acc_byte;
                        end
                    end
                    if (in_data.last_item)
                    begin
                        state_next = PS_FIRST;
                    end
                end
            end
            PS_FIRST:
            begin
                push_item.word = acc_reg | (32'h8000_0000 >> {cnt_reg, 3'b000});
                if (push_ready)
                begin
                    push       = 1'b1;
                    idx_next   = idx_inc;
                    state_next = (idx_inc == 4'd14) ? PS_LENHI : PS_ZERO;
                end
            end
            PS_ZERO:
            begin
                push_item.word = '0;
                if (push_ready)
                begin
                    push     = 1'b1;
                    idx_next = idx_inc;
                    if (idx_inc == 4'd14)
                    begin
                        state_next = PS_LENHI;
                    end
                end
            end
            PS_LENHI:
            begin
                push_item.word = bits_reg[63:32];
                if (push_ready)
                begin
                    push       = 1'b1;
                    idx_next   = idx_inc;
                    state_next = PS_LENLO;
                end
            end
            PS_LENLO:
            begin
                push_item.word        = bits_reg[31:0];
                push_item.final_block = 1'b1;
                if (push_ready)
                begin
                    push       = 1'b1;
                    idx_next   = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    bits_next  = '0;
                    state_next = PS_IDLE;
                end
            end
            default:
            begin
                state_next = PS_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            bits_reg  <= bits_next;
        end
    end

endmodule

// ----- hdl/sha256h_queue.sv -----
// short word queue between the front end and the compression core
// depends on sha256h_pkg
module sha256h_queue
    import sha256h_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  word_item_t push_item,
    output logic       push_ready,
    input  logic       pop,
    output word_item_t pop_item,
    output logic       pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/sha256h_core.sv -----
// compression core: loads 16 words, runs 64 rounds, chains, emits digest
// depends on sha256h_pkg
module sha256h_core
    import sha256h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    input  word_item_t pop_item,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output digest_t    out_data
);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]  state_reg;
    logic [5:0]  round_reg;
    logic        final_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic        out_valid_reg;
    digest_t     out_data_reg;

    logic [31:0] t1, t2, w_new;
    logic [31:0] sum [8];
    logic        emit;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = (state_reg == ST_LOAD) && pop_valid;
    assign emit      = (state_reg == ST_FINISH) && final_reg &&
                       (!out_valid_reg || out_ready);

    // one round of the compression function
    always_comb
    begin
        t1 = v_reg[7] + big_sig1(v_reg[4]) +
             ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) +
             ROUND_K[round_reg] + w_reg[0];
        t2 = big_sig0(v_reg[0]) +
             ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = small_sig1(w_reg[14]) + w_reg[9] + small_sig0(w_reg[1]) + w_reg[0];
        for (int i = 0; i < 8; i++)
        begin
            sum[i] = chain_reg[i] + v_reg[i];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (pop && pop_item.end_block)
                    begin
                        final_reg <= pop_item.final_block;
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!final_reg)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_reg[i] <= sum[i];
                        end
                        state_reg <= ST_LOAD;
                    end
                    else if (emit)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_reg[i] <= INIT_HASH[i];
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // datapath: schedule window, working variables, digest register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= pop_item.word;
            if (pop_item.end_block)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= chain_reg[i];
                end
            end
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            v_reg[7]  <= v_reg[6];
            v_reg[6]  <= v_reg[5];
            v_reg[5]  <= v_reg[4];
            v_reg[4]  <= v_reg[3] + t1;
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= v_reg[1];
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= t1 + t2;
        end
        if (emit)
        begin
            out_data_reg <= '{sum[0], sum[1], sum[2], sum[3],
                              sum[4], sum[5], sum[6], sum[7]};
        end
    end

endmodule
